// ===== rtl/core/pso_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, constants and tables of the path-scanning oscillator.
// ----------------------------------------------------------------------------
package pso_pkg;

    localparam int PATH_DEPTH  = 8192;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 32;
    localparam int ADDR_W      = 13;
    localparam int LEN_W       = 14;
    localparam int RATE_W      = 19;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;

    localparam logic [LEN_W-1:0]  PATH_LENGTH_RST = 14'd0;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 19'd48000;

    localparam logic [15:0] WARP_LO = 16'd66;
    localparam logic [15:0] WARP_HI = 16'd65470;

    typedef struct packed {
        logic                   is_write;
        logic signed [15:0]     cv;
        logic [31:0]            frequency;
        logic [31:0]            phase_offset;
        logic                   reset_level;
        logic [15:0]            sharpness;
        logic [ADDR_W-1:0]      point_index;
        logic signed [15:0]     point_x;
        logic signed [15:0]     point_y;
    } t_item;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q2.30, k = 1..12
    function automatic logic [11:0][31:0] exp_tab();
        logic [63:0]       c;
        logic [11:0][31:0] t;
        c = isqrt64(64'd2 << 60);
        for (int k = 0; k < 12; k++) begin
            t[k] = c[31:0];
            c = isqrt64(c << 30);
        end
        return t;
    endfunction

    localparam logic [11:0][31:0] EXP_TAB = exp_tab();

endpackage
`default_nettype wire

// ===== rtl/core/pso_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pso_front
// Input stage: accepts requests, tags them as write or sample, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pso_front
    import pso_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_mode,
    input  wire logic signed [15:0] i_cv,
    input  wire logic [31:0]        i_frequency,
    input  wire logic [31:0]        i_phase_offset,
    input  wire logic               i_reset_level,
    input  wire logic [15:0]        i_sharpness,
    input  wire logic [ADDR_W-1:0]  i_point_index,
    input  wire logic signed [15:0] i_point_x,
    input  wire logic signed [15:0] i_point_y,
    output logic                    o_head_valid,
    output t_item                   o_head,
    input  wire logic               i_pop
);

    t_item       r_q [2];
    logic        r_rd;
    logic        r_wr;
    logic [1:0]  r_cnt;
    t_item       w_item;
    logic        w_push;

    always_comb begin
        w_item.is_write     = i_mode;
        w_item.cv           = i_cv;
        w_item.frequency    = i_frequency;
        w_item.phase_offset = i_phase_offset;
        w_item.reset_level  = i_reset_level;
        w_item.sharpness    = i_sharpness;
        w_item.point_index  = i_point_index;
        w_item.point_x      = i_point_x;
        w_item.point_y      = i_point_y;
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && o_head_valid) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, i_pop && o_head_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pso_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pso_div
// Restoring divider, one quotient bit per cycle, shared by the phase
// increment and the warp.
// ----------------------------------------------------------------------------
module pso_div
    import pso_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_dividend,
    input  wire logic [RATE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [63:0]            o_quotient
);

    logic [RATE_W-1:0] r_rem;
    logic [63:0]       r_quo;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RATE_W:0]   w_rem_t;
    logic              w_ge;
    logic [RATE_W:0]   w_diff;

    assign w_rem_t    = {r_rem, r_quo[63]};
    assign w_ge       = (w_rem_t >= {1'b0, i_divisor});
    assign w_diff     = w_rem_t - {1'b0, i_divisor};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[RATE_W-1:0] : w_rem_t[RATE_W-1:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= 7'd64;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pso_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pso_back
// Execution sequencer: stores path points, runs the phase accumulator,
// warp and interpolation, and holds the result register.
// ----------------------------------------------------------------------------
module pso_back
    import pso_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_head_valid,
    input  wire t_item                   i_head,
    output logic                         o_pop,
    input  wire logic [LEN_W-1:0]        i_path_length,
    input  wire logic [RATE_W-1:0]       i_sample_rate,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_x_out,
    output logic signed [SAMPLE_BITS-1:0] o_y_out
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXP   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_DIV1  = 4'd3;
    localparam logic [3:0] ST_SHIFT = 4'd4;
    localparam logic [3:0] ST_WARP  = 4'd5;
    localparam logic [3:0] ST_DIV2  = 4'd6;
    localparam logic [3:0] ST_IDX   = 4'd7;
    localparam logic [3:0] ST_SEL   = 4'd8;
    localparam logic [3:0] ST_RD1   = 4'd9;
    localparam logic [3:0] ST_RD2   = 4'd10;
    localparam logic [3:0] ST_RD3   = 4'd11;
    localparam logic [3:0] ST_LERP  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0]         r_state;
    t_item              r_item;
    logic [PHASE_BITS-1:0] r_phase;
    logic               r_prev_rst;
    logic signed [7:0]  r_ip;
    logic [11:0]        r_f;
    logic [3:0]         r_k;
    logic [31:0]        r_m;
    logic [63:0]        r_dvd;
    logic [RATE_W-1:0]  r_dvs;
    logic               r_start;
    logic [32:0]        r_pos;
    logic [45:0]        r_idx;
    logic [ADDR_W-1:0]  r_i0;
    logic [16:0]        r_t;
    logic [31:0]        r_a0;
    logic [31:0]        r_a1;
    logic signed [34:0] r_px;
    logic signed [34:0] r_py;
    logic               r_zero;
    logic               r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;

    logic [31:0]        r_mem [PATH_DEPTH];
    logic [31:0]        r_rdata;
    logic               w_we;
    logic [ADDR_W-1:0]  w_raddr;

    logic               w_done;
    logic [63:0]        w_quo;

    logic [LEN_W-1:0]   w_n;
    logic [RATE_W-1:0]  w_rate;
    logic signed [19:0] w_e;
    logic [63:0]        w_mc;
    logic signed [8:0]  w_s;
    logic [6:0]         w_sh;
    logic [63:0]        w_hi;
    logic [63:0]        w_qs;
    logic               w_sat;
    logic [PHASE_BITS-1:0] w_inc;
    logic [31:0]        w_ep;
    logic [15:0]        w_w;
    logic               w_lt;
    logic [63:0]        w_num;
    logic [RATE_W-1:0]  w_den;
    logic [LEN_W-1:0]   w_top;
    logic [LEN_W-1:0]   w_nm2;
    logic [LEN_W-1:0]   w_i0;
    logic [33:0]        w_rnd;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [34:0] w_qx;
    logic signed [34:0] w_qy;
    logic signed [SAMPLE_BITS-1:0] w_lx;
    logic signed [SAMPLE_BITS-1:0] w_ly;
    logic               w_load;

    pso_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_done),
        .o_quotient (w_quo)
    );

    assign o_pop       = (r_state == ST_IDLE) && i_head_valid;
    assign w_we        = o_pop && i_head.is_write;
    assign w_raddr     = (r_state == ST_RD2) ? (r_i0 + 13'd1) : r_i0;
    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_x;
    assign o_y_out     = r_y;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_head.point_index] <= {i_head.point_x, i_head.point_y};
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        w_n    = (i_path_length > LEN_W'(PATH_DEPTH)) ? '0 : i_path_length;
        w_rate = (i_sample_rate == '0) ? RATE_W'(1) : i_sample_rate;
        w_e    = 20'(i_head.cv) * 20'sd10;
        w_mc   = r_m * EXP_TAB[11 - r_k];

        w_s  = 9'(r_ip) - 9'sd14;
        w_sh = 7'(-w_s);
        w_hi = '0;
        w_qs = '0;
        if (w_s < 0) begin
            w_qs  = (w_sh >= 7'd64) ? 64'd0 : (w_quo >> w_sh);
            w_sat = (w_qs[63:32] != '0);
        end else if (w_s >= 9'sd64) begin
            w_sat = 1'b1;
        end else if (w_s > 9'sd32) begin
            w_sat = (w_quo != '0);
        end else begin
            w_hi  = w_quo >> (7'd32 - 7'(w_s));
            w_sat = (w_hi != '0);
            w_qs  = w_quo << 7'(w_s);
        end
        w_inc = w_sat ? '1 : w_qs[PHASE_BITS-1:0];

        w_ep = r_phase + r_item.phase_offset;
        w_w  = r_item.sharpness;
        if (w_w < WARP_LO) begin
            w_w = WARP_LO;
        end
        if (w_w > WARP_HI) begin
            w_w = WARP_HI;
        end
        w_lt  = ({16'd0, w_ep} < {w_w, 16'd0});
        w_num = w_lt ? {16'd0, w_ep, 16'd0}
                     : ({31'd0, 33'h1_0000_0000 - {1'b0, w_ep}} << 16);
        w_den = w_lt ? {3'd0, w_w} : RATE_W'(17'h10000 - {1'b0, w_w});

        w_top = r_idx[45:32];
        w_nm2 = w_n - LEN_W'(2);
        w_i0  = (w_top > w_nm2) ? w_nm2 : w_top;
        w_rnd = {1'b0, (w_top != w_i0), r_idx[31:0]} + 34'd32768;

        w_dx = 17'(signed'(r_a1[31:16])) - 17'(signed'(r_a0[31:16]));
        w_dy = 17'(signed'(r_a1[15:0])) - 17'(signed'(r_a0[15:0]));
        w_qx = (r_px + 35'sd32768) >>> 16;
        w_qy = (r_py + 35'sd32768) >>> 16;
        w_lx = SAMPLE_BITS'(35'(signed'(r_a0[31:16])) + w_qx);
        w_ly = SAMPLE_BITS'(35'(signed'(r_a0[15:0])) + w_qy);

        w_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_item <= i_head;
                    r_ip   <= 8'(w_e >>> 12);
                    r_f    <= w_e[11:0];
                    r_k    <= 4'd11;
                    r_m    <= 32'h4000_0000;
                end
            end
            ST_EXP: begin
                if (r_f[r_k]) begin
                    r_m <= 32'((w_mc + 64'h2000_0000) >> 30);
                end
                r_k <= r_k - 4'd1;
            end
            ST_MUL: begin
                r_dvd <= r_item.frequency * r_m;
                r_dvs <= w_rate;
            end
            ST_SHIFT: begin
                r_zero <= (w_n < LEN_W'(2));
            end
            ST_WARP: begin
                r_dvd <= w_num;
                r_dvs <= w_den;
            end
            ST_DIV2: begin
                r_pos <= w_quo[32:0];
            end
            ST_IDX: begin
                r_idx <= r_pos * 13'(w_n - LEN_W'(1));
            end
            ST_SEL: begin
                r_i0 <= w_i0[ADDR_W-1:0];
                r_t  <= w_rnd[32:16];
            end
            ST_RD2: begin
                r_a0 <= r_rdata;
            end
            ST_RD3: begin
                r_a1 <= r_rdata;
            end
            ST_LERP: begin
                r_px <= 35'(w_dx) * 35'(signed'({1'b0, r_t}));
                r_py <= 35'(w_dy) * 35'(signed'({1'b0, r_t}));
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (w_load) begin
            r_x <= r_zero ? '0 : w_lx;
            r_y <= r_zero ? '0 : w_ly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_prev_rst  <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && !i_head.is_write) begin
                        if (i_head.reset_level && !r_prev_rst) begin
                            r_phase <= '0;
                        end
                        r_prev_rst <= i_head.reset_level;
                        r_state    <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    if (r_k == 4'd0) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_start <= 1'b1;
                    r_state <= ST_DIV1;
                end
                ST_DIV1: begin
                    if (w_done) begin
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_phase <= r_phase + w_inc;
                    r_state <= (w_n < LEN_W'(2)) ? ST_OUT : ST_WARP;
                end
                ST_WARP: begin
                    r_start <= 1'b1;
                    r_state <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (w_done) begin
                        r_state <= ST_IDX;
                    end
                end
                ST_IDX:  r_state <= ST_SEL;
                ST_SEL:  r_state <= ST_RD1;
                ST_RD1:  r_state <= ST_RD2;
                ST_RD2:  r_state <= ST_RD3;
                ST_RD3:  r_state <= ST_LERP;
                ST_LERP: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/path_scanning_oscillator.sv =====
`default_nettype none
// A path write is stored in the back end as it leaves the queue. The back end
// takes one sample at a time, through the 12-step pitch exponent loop and two
// 64-step passes of the shared divider; a path shorter than two points skips
// the warp pass and the lookup.
// Reset clears the phase, the queue and the registers (path_length 0,
// sample_rate 48000); path points are undefined until written.
// ----------------------------------------------------------------------------
// path_scanning_oscillator
// Oscillator that scans a stored X/Y path with linear interpolation.
// ----------------------------------------------------------------------------
module path_scanning_oscillator
    import pso_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_mode,
    input  wire logic signed [15:0]     i_cv,
    input  wire logic [31:0]            i_frequency,
    input  wire logic [31:0]            i_phase_offset,
    input  wire logic                   i_reset_level,
    input  wire logic [15:0]            i_sharpness,
    input  wire logic [ADDR_W-1:0]      i_point_index,
    input  wire logic signed [15:0]     i_point_x,
    input  wire logic signed [15:0]     i_point_y,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_x_out,
    output logic signed [SAMPLE_BITS-1:0] o_y_out,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0]  r_path_length;
    logic [RATE_W-1:0] r_sample_rate;
    logic              w_head_valid;
    t_item             w_head;
    logic              w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_length <= PATH_LENGTH_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATH_LENGTH: r_path_length <= i_cfg_data[LEN_W-1:0];
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[RATE_W-1:0];
                default:         r_path_length <= r_path_length;
            endcase
        end
    end

    pso_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_cv           (i_cv),
        .i_frequency    (i_frequency),
        .i_phase_offset (i_phase_offset),
        .i_reset_level  (i_reset_level),
        .i_sharpness    (i_sharpness),
        .i_point_index  (i_point_index),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    pso_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_path_length (r_path_length),
        .i_sample_rate (r_sample_rate),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_x_out       (o_x_out),
        .o_y_out       (o_y_out)
    );

endmodule
`default_nettype wire

// ===== sim/tb_path_scanning_oscillator.sv =====
// ----------------------------------------------------------------------------
// tb_path_scanning_oscillator
// Self-checking bench for the path-scanning oscillator. Path points, sample
// requests and register writes go over valid/ready channels, the first two
// with random idling; every sample is predicted in fixed point and compared.
// ----------------------------------------------------------------------------
module tb_path_scanning_oscillator
    import pso_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILL = 128;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    class pso_scoreboard;
        int unsigned        errors;
        logic [LEN_W-1:0]   path_len;
        logic [RATE_W-1:0]  rate;
        logic [31:0]        phase;
        bit                 last_level;
        logic signed [15:0] px [PATH_DEPTH];
        logic signed [15:0] py [PATH_DEPTH];
        logic [63:0]        root_tab [12];
        t_point             due [$];

        function logic [63:0] root64(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function new();
            logic [63:0] c;
            errors     = 0;
            path_len   = PATH_LENGTH_RST;
            rate       = SAMPLE_RATE_RST;
            phase      = '0;
            last_level = 1'b0;
            c = root64(64'd2 << 60);
            for (int k = 0; k < 12; k++) begin
                root_tab[k] = c;
                c = root64(c << 30);
            end
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_PATH_LENGTH) path_len = d[LEN_W-1:0];
            else if (idx == CFG_SAMPLE_RATE) rate = d[RATE_W-1:0];
        endfunction

        function logic [31:0] step_of(logic signed [15:0] cv, logic [31:0] freq);
            int          e;
            int          ip;
            int          sh;
            logic [11:0] f;
            logic [63:0] m;
            logic [63:0] q;
            logic [63:0] mask;
            mask = 64'hFFFF_FFFF;
            e  = 10 * int'(cv);
            ip = e >>> 12;
            f  = e[11:0];
            m  = 64'd1 << 30;
            for (int k = 0; k < 12; k++)
                if (f[11-k]) m = (m * root_tab[k] + (64'd1 << 29)) >> 30;
            q  = (64'(freq) * m) / ((rate == 0) ? 64'd1 : 64'(rate));
            sh = ip - 14;
            if (sh < 0) begin
                q = (-sh >= 64) ? 64'd0 : q >> (-sh);
            end else if (sh > 0) begin
                if (sh >= 64 || q > (mask >> sh)) q = mask;
                else q = q << sh;
            end
            if (q > mask) q = mask;
            return q[31:0];
        endfunction

        function logic signed [15:0] blend(logic signed [15:0] a0, logic signed [15:0] a1,
                                           longint t16);
            longint v;
            v = (longint'(a1) - longint'(a0)) * t16 + 32768;
            v = longint'(a0) + (v >>> 16);
            return v[15:0];
        endfunction

        function void note(t_item it);
            int unsigned n;
            logic [31:0] e32;
            logic [63:0] w;
            logic [63:0] pos;
            logic [63:0] idx;
            logic [63:0] i0;
            logic [63:0] t16;
            t_point      p;
            if (it.is_write) begin
                px[it.point_index] = it.point_x;
                py[it.point_index] = it.point_y;
                return;
            end
            if (it.reset_level && !last_level) phase = '0;
            last_level = it.reset_level;
            phase = phase + step_of(it.cv, it.frequency);
            n = (path_len > PATH_DEPTH) ? 0 : path_len;
            if (n < 2) begin
                p.x = '0;
                p.y = '0;
                due.push_back(p);
                return;
            end
            e32 = phase + it.phase_offset;
            w = it.sharpness;
            if (w < WARP_LO) w = WARP_LO;
            if (w > WARP_HI) w = WARP_HI;
            if (64'(e32) < (w << 16)) pos = (64'(e32) << 16) / w;
            else pos = (((64'd1 << 32) - 64'(e32)) << 16) / (64'd65536 - w);
            idx = pos * (n - 1);
            i0  = idx >> 32;
            if (i0 > n - 2) i0 = n - 2;
            t16 = ((idx - (i0 << 32)) + 64'd32768) >> 16;
            p.x = blend(px[i0], px[i0+1], longint'(t16));
            p.y = blend(py[i0], py[i0+1], longint'(t16));
            due.push_back(p);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check(logic signed [15:0] x, logic signed [15:0] y);
            t_point p;
            if (due.size() == 0) begin
                report_mismatch($sformatf("unexpected sample x=%0d y=%0d", x, y));
                return;
            end
            p = due.pop_front();
            if (x !== p.x) report_mismatch($sformatf("x_out %0d, predicted %0d", x, p.x));
            if (y !== p.y) report_mismatch($sformatf("y_out %0d, predicted %0d", y, p.y));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_item                 req = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    logic signed [SAMPLE_BITS-1:0] o_x_out;
    logic signed [SAMPLE_BITS-1:0] o_y_out;

    int unsigned send_idle = 19;
    int unsigned recv_idle = 54;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    bit          level = 1'b0;

    pso_scoreboard sb = new();

    path_scanning_oscillator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (req.is_write),
        .i_cv           (req.cv),
        .i_frequency    (req.frequency),
        .i_phase_offset (req.phase_offset),
        .i_reset_level  (req.reset_level),
        .i_sharpness    (req.sharpness),
        .i_point_index  (req.point_index),
        .i_point_x      (req.point_x),
        .i_point_y      (req.point_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note(req);
            if (cfg_valid && o_cfg_ready) sb.configure(cfg_idx, cfg_data);
            if (o_out_valid && out_ready) sb.check(o_x_out, o_y_out);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic offer(t_item it);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        req      <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_point(int unsigned ix, logic [15:0] x, logic [15:0] y);
        t_item it;
        it = '0;
        it.is_write    = 1'b1;
        it.cv          = 16'($urandom);
        it.frequency   = $urandom;
        it.point_index = ADDR_W'(ix);
        it.point_x     = x;
        it.point_y     = y;
        offer(it);
    endtask

    task automatic play(logic [15:0] cv, logic [31:0] freq, logic [31:0] off,
                        logic lvl, logic [15:0] sharp);
        t_item it;
        it = '0;
        it.cv           = cv;
        it.frequency    = freq;
        it.phase_offset = off;
        it.reset_level  = lvl;
        it.sharpness    = sharp;
        it.point_index  = ADDR_W'($urandom);
        it.point_x      = 16'($urandom);
        it.point_y      = 16'($urandom);
        offer(it);
    endtask

    task automatic random_item();
        logic [15:0] cv;
        logic [31:0] freq;
        logic [15:0] sharp;
        if ($urandom_range(99) < 15) begin
            put_point($urandom_range(PATH_DEPTH - 1), 16'($urandom), 16'($urandom));
            return;
        end
        cv    = ($urandom_range(99) < 65) ? 16'($urandom_range(8191) - 4096) : 16'($urandom);
        freq  = ($urandom_range(99) < 50) ? $urandom_range(32'h0400_0000) : $urandom;
        sharp = ($urandom_range(99) < 15) ? 16'($urandom_range(70)) : 16'($urandom);
        if ($urandom_range(99) < 12) level = ~level;
        play(cv, freq, $urandom, level, sharp);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        play(16'h8000, 32'hFFFF_FFFF, 32'h0, 1'b0, 16'h0);
        play(16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        play(16'h0, 32'h0, 32'h8000_0000, 1'b0, 16'h8000);

        for (int i = 0; i < FILL; i++) begin
            if (i == 0) put_point(i, 16'h7FFF, 16'h8000);
            else if (i == FILL - 1) put_point(i, 16'h8000, 16'h7FFF);
            else put_point(i, 16'($urandom), 16'($urandom));
        end

        cfg_write(CFG_PATH_LENGTH, 19'd2);
        play(16'h0, 32'h01B8_0000, 32'h0, 1'b1, 16'h0);
        play(16'h0, 32'h01B8_0000, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        play(16'h0, 32'h01B8_0000, 32'h4000_0000, 1'b0, 16'd66);
        play(16'h0, 32'h01B8_0000, 32'hC000_0000, 1'b1, 16'd65470);
        play(16'h7FFF, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 16'h8000);
        play(16'h8000, 32'hFFFF_FFFF, 32'h0, 1'b0, 16'h8000);
        play(16'h1000, 32'h0001_0000, 32'h0, 1'b1, 16'h8000);
        cfg_write(CFG_PATH_LENGTH, CFG_DATA_W'(FILL));
        cfg_write(CFG_SAMPLE_RATE, 19'd1);
        play(16'h0, 32'h0000_0001, 32'h0, 1'b0, 16'h8000);
        play(16'hF000, 32'h0100_0000, 32'h8000_0000, 1'b1, 16'h4000);

        for (int ph = 0; ph < 12; ph++) begin
            send_idle = (ph < 4) ? 19 : (ph < 8) ? 54 : 0;
            recv_idle = (ph < 4) ? 54 : (ph < 8) ? 19 : 0;
            case (ph)
                0: begin
                    cfg_write(CFG_PATH_LENGTH, 19'd2);
                    cfg_write(CFG_SAMPLE_RATE, 19'd48000);
                end
                1: begin
                    cfg_write(CFG_PATH_LENGTH, CFG_DATA_W'(FILL));
                    cfg_write(CFG_SAMPLE_RATE, 19'd400000);
                end
                2: begin
                    cfg_write(CFG_PATH_LENGTH, 19'd3);
                    cfg_write(CFG_SAMPLE_RATE, 19'd1);
                end
                3: begin
                    cfg_write(CFG_PATH_LENGTH, 19'd16383);
                    cfg_write(CFG_SAMPLE_RATE, 19'd0);
                end
                4: begin
                    cfg_write(CFG_PATH_LENGTH, 19'd1);
                    cfg_write(CFG_SAMPLE_RATE, 19'd524287);
                end
                default: begin
                    cfg_write(CFG_PATH_LENGTH, CFG_DATA_W'($urandom_range(2, FILL)));
                    cfg_write(CFG_SAMPLE_RATE, CFG_DATA_W'($urandom_range(1, 400000)));
                end
            endcase
            if (ph == 9) hold_req <= 1'b1;
            for (int k = 0; k < 60; k++) begin
                if (ph == 5 && k == 30) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.due.size() != 0) @(posedge i_clk);
                end
                random_item();
            end
        end

        drain();
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pso_pkg.sv
rtl/core/pso_front.sv
rtl/core/pso_div.sv
rtl/core/pso_back.sv
rtl/core/path_scanning_oscillator.sv
sim/tb_path_scanning_oscillator.sv
